>>> hdl/wmaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmaf_pkg
// Shared types, codes and defaults of the weighted moving-average filter.
// ----------------------------------------------------------------------------
package wmaf_pkg;

  localparam int MAX_WINDOW_DEF       = 32;
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int          ALPHA_BITS = 16;
  localparam logic [16:0] ALPHA_ONE  = 17'h10000;

  // register map
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // weight profiles
  localparam logic [2:0] MODE_UNIFORM  = 3'd0;
  localparam logic [2:0] MODE_LINEAR   = 3'd1;
  localparam logic [2:0] MODE_EXP      = 3'd2;
  localparam logic [2:0] MODE_TRIANGLE = 3'd3;
  localparam logic [2:0] MODE_CUSTOM   = 3'd4;

  localparam logic [5:0]  WINDOW_RST = 6'd8;
  localparam logic [16:0] ALPHA_RST  = 17'd32768;

  // result status
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ZERO   = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_REINIT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_CUSTOM = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROF,
    ST_SUM,
    ST_MAC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic mac_step;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic custom_ok;
    logic sweep_last;
    logic mac_done;
    logic total_zero;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> hdl/wmaf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmaf_cfg
// APB-style register file: window length, weight profile and decay alpha.
// ----------------------------------------------------------------------------
module wmaf_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [5:0]  window_length,
  output logic      [2:0]  weight_mode,
  output logic      [16:0] decay_alpha
);

  logic [5:0]  window_length_r, window_length_nxt;
  logic [2:0]  weight_mode_r, weight_mode_nxt;
  logic [16:0] decay_alpha_r, decay_alpha_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    window_length_nxt = window_length_r;
    weight_mode_nxt   = weight_mode_r;
    decay_alpha_nxt   = decay_alpha_r;
    if (wr_en) begin
      case (paddr[3:2])
        wmaf_pkg::REG_WINDOW: window_length_nxt = pwdata[5:0];
        wmaf_pkg::REG_MODE:   weight_mode_nxt   = pwdata[2:0];
        wmaf_pkg::REG_ALPHA:  decay_alpha_nxt   = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wmaf_pkg::REG_WINDOW: prdata = {26'd0, window_length_r};
      wmaf_pkg::REG_MODE:   prdata = {29'd0, weight_mode_r};
      wmaf_pkg::REG_ALPHA:  prdata = {15'd0, decay_alpha_r};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= wmaf_pkg::WINDOW_RST;
      weight_mode_r   <= wmaf_pkg::MODE_UNIFORM;
      decay_alpha_r   <= wmaf_pkg::ALPHA_RST;
    end else begin
      window_length_r <= window_length_nxt;
      weight_mode_r   <= weight_mode_nxt;
      decay_alpha_r   <= decay_alpha_nxt;
    end
  end

  assign window_length = window_length_r;
  assign weight_mode   = weight_mode_r;
  assign decay_alpha   = decay_alpha_r;

endmodule
`default_nettype wire

>>> hdl/wmaf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmaf_ctrl
// Sequencer: profile sweep, weight sum sweep, multiply-accumulate, divide.
// ----------------------------------------------------------------------------
module wmaf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_operation,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire wmaf_pkg::stat_t stat,
  output wmaf_pkg::cmd_t       cmd
);

  wmaf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmaf_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (wmaf_pkg::op_t'(in_operation))
            wmaf_pkg::OP_SAMPLE: state_nxt = wmaf_pkg::ST_MAC;
            wmaf_pkg::OP_REINIT: state_nxt = wmaf_pkg::ST_PROF;
            wmaf_pkg::OP_CUSTOM: state_nxt = stat.custom_ok ? wmaf_pkg::ST_SUM
                                                            : wmaf_pkg::ST_DONE;
            default:             state_nxt = wmaf_pkg::ST_DONE;
          endcase
        end
      end
      wmaf_pkg::ST_PROF, wmaf_pkg::ST_SUM: begin
        if (stat.sweep_last) state_nxt = wmaf_pkg::ST_DONE;
      end
      wmaf_pkg::ST_MAC: begin
        if (stat.mac_done) begin
          state_nxt = stat.total_zero ? wmaf_pkg::ST_DONE : wmaf_pkg::ST_DIV;
        end
      end
      wmaf_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = wmaf_pkg::ST_DONE;
      end
      wmaf_pkg::ST_DONE: begin
        if (slot_free) state_nxt = wmaf_pkg::ST_IDLE;
      end
      default: state_nxt = wmaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = (state_r != wmaf_pkg::ST_IDLE);
    cmd.load       = (state_r == wmaf_pkg::ST_IDLE) && in_valid;
    cmd.sweep_step = (state_r == wmaf_pkg::ST_PROF) || (state_r == wmaf_pkg::ST_SUM);
    cmd.mac_step   = (state_r == wmaf_pkg::ST_MAC) && !stat.mac_done;
    cmd.div_start  = (state_r == wmaf_pkg::ST_MAC) && stat.mac_done;
    cmd.div_step   = (state_r == wmaf_pkg::ST_DIV) && !stat.div_done;
    cmd.div_finish = (state_r == wmaf_pkg::ST_DIV) && stat.div_done;
    cmd.out_load   = (state_r == wmaf_pkg::ST_DONE) && slot_free;
  end

  // output word stays until taken
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != wmaf_pkg::ST_IDLE))
    else $error("accepted word did not start work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending word");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmaf_pkg::ST_DIV) |-> !stat.total_zero)
    else $error("divide entered with zero weight sum");

endmodule
`default_nettype wire

>>> hdl/wmaf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmaf_dp
// Datapath: history and weight tables, profile builder, MAC and divider.
// ----------------------------------------------------------------------------
module wmaf_dp #(
  parameter int MAX_WINDOW       = wmaf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS      = wmaf_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = wmaf_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wmaf_pkg::cmd_t                cmd,
  output wmaf_pkg::stat_t                    stat,
  input  wire logic [1:0]                    in_operation,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [4:0]                    in_weight_index,
  input  wire logic [23:0]                   in_weight_value,
  input  wire logic [5:0]                    window_length,
  input  wire logic [2:0]                    weight_mode,
  input  wire logic [16:0]                   decay_alpha,
  output logic signed [SAMPLE_BITS-1:0]      out_filtered,
  output logic [1:0]                         out_status
);

  localparam int WW        = 8 + WEIGHT_FRAC_BITS;
  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int NW        = $clog2(MAX_WINDOW + 1);
  localparam int TW        = WW + AW;
  localparam int ACCW      = SAMPLE_BITS + WW + AW;
  localparam int CW        = $clog2(ACCW + 1);
  localparam int EXP_SHIFT = 2 * wmaf_pkg::ALPHA_BITS - WEIGHT_FRAC_BITS;

  localparam logic [WW-1:0]   WEIGHT_ONE = WW'(64'd1 << WEIGHT_FRAC_BITS);
  localparam logic [WW-1:0]   WEIGHT_MAX = '1;
  localparam logic [TW-1:0]   TOTAL_RST  = TW'(64'd8 << WEIGHT_FRAC_BITS);
  localparam logic [ACCW-1:0] SAT_HI     = ACCW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SAMPLE_BITS-1:0] OUT_HI = SAMPLE_BITS'(SAT_HI);
  localparam logic [SAMPLE_BITS-1:0] OUT_LO = ~OUT_HI;

  logic signed [SAMPLE_BITS-1:0] hist_r [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] hist_nxt [MAX_WINDOW];
  logic [WW-1:0]                 wtab_r [MAX_WINDOW];
  logic [WW-1:0]                 wtab_nxt [MAX_WINDOW];

  logic [AW-1:0]          wpos_r, wpos_nxt;
  logic                   full_r, full_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic [TW-1:0]          sum_r, sum_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [ACCW-1:0] prod_r, prod_nxt;
  logic                   pvalid_r, pvalid_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [NW-1:0]          count_r, count_nxt;
  logic [16:0]            factor_r, factor_nxt;
  wmaf_pkg::op_t          op_r, op_nxt;
  logic [ACCW-1:0]        dvd_r, dvd_nxt;
  logic [TW-1:0]          rem_r, rem_nxt;
  logic                   neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0] res_filtered_r, res_filtered_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [SAMPLE_BITS-1:0] out_filtered_r, out_filtered_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic [NW-1:0]   n;
  logic [16:0]     alpha;
  logic [NW-1:0]   pn;
  logic [NW:0]     tap;
  logic [AW-1:0]   hidx;
  logic [AW-1:0]   widx;
  logic [NW-1:0]   iv;
  logic [NW-1:0]   ramp;
  logic [33:0]     mul_w;
  logic [33:0]     mul_f;
  logic [WW-1:0]   wbuild;
  logic [WW-1:0]   wsweep;
  logic            in_win;
  logic [TW:0]     rem_sh;
  logic            ge;
  logic [ACCW-1:0] acc_mag;

  // effective window and alpha
  always_comb begin
    if (window_length == 6'd0) n = NW'(1);
    else if (32'(window_length) > MAX_WINDOW) n = NW'(MAX_WINDOW);
    else n = NW'(window_length);
    if (decay_alpha == 17'd0) alpha = 17'd1;
    else if (decay_alpha > wmaf_pkg::ALPHA_ONE) alpha = wmaf_pkg::ALPHA_ONE;
    else alpha = decay_alpha;
  end

  // profile weight for the swept entry
  assign iv    = NW'(cnt_r[AW-1:0]);
  assign mul_w = 34'(alpha) * 34'(factor_r);
  assign mul_f = 34'(factor_r) * 34'(wmaf_pkg::ALPHA_ONE - alpha);
  always_comb begin
    ramp = n - iv;
    if (weight_mode == wmaf_pkg::MODE_TRIANGLE && iv <= (n >> 1)) ramp = iv + NW'(1);
    case (weight_mode)
      wmaf_pkg::MODE_LINEAR, wmaf_pkg::MODE_TRIANGLE: begin
        if (32'(ramp) > 255) wbuild = WEIGHT_MAX;
        else wbuild = WW'(ramp) << WEIGHT_FRAC_BITS;
      end
      wmaf_pkg::MODE_EXP:    wbuild = WW'(mul_w >> EXP_SHIFT);
      wmaf_pkg::MODE_CUSTOM: wbuild = '0;
      default:               wbuild = WEIGHT_ONE;
    endcase
  end

  assign in_win = cnt_r < CW'(n);
  assign wsweep = (op_r == wmaf_pkg::OP_REINIT) ? (in_win ? wbuild : '0)
                                                : (in_win ? wtab_r[cnt_r[AW-1:0]] : '0);

  // newest-first tap address
  always_comb begin
    tap = (NW+1)'(wpos_r) + (NW+1)'(n) - (NW+1)'(1) - (NW+1)'(cnt_r[NW-1:0]);
    if (tap >= (NW+1)'(n)) tap = tap - (NW+1)'(n);
  end
  assign hidx = tap[AW-1:0];
  assign widx = AW'(in_weight_index);

  assign rem_sh  = {rem_r, dvd_r[ACCW-1]};
  assign ge      = rem_sh >= {1'b0, total_r};
  assign acc_mag = acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);

  always_comb begin
    pn = NW'(wpos_r) + NW'(1);

    hist_nxt         = hist_r;
    wtab_nxt         = wtab_r;
    wpos_nxt         = wpos_r;
    full_nxt         = full_r;
    total_nxt        = total_r;
    sum_nxt          = sum_r;
    acc_nxt          = acc_r;
    prod_nxt         = prod_r;
    pvalid_nxt       = pvalid_r;
    cnt_nxt          = cnt_r;
    count_nxt        = count_r;
    factor_nxt       = factor_r;
    op_nxt           = op_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    neg_nxt          = neg_r;
    res_filtered_nxt = res_filtered_r;
    res_status_nxt   = res_status_r;
    out_filtered_nxt = out_filtered_r;
    out_status_nxt   = out_status_r;

    if (cmd.load) begin
      op_nxt           = wmaf_pkg::op_t'(in_operation);
      cnt_nxt          = '0;
      sum_nxt          = '0;
      acc_nxt          = '0;
      pvalid_nxt       = 1'b0;
      factor_nxt       = wmaf_pkg::ALPHA_ONE;
      res_filtered_nxt = '0;
      res_status_nxt   = wmaf_pkg::STATUS_OK;
      case (wmaf_pkg::op_t'(in_operation))
        wmaf_pkg::OP_SAMPLE: begin
          hist_nxt[wpos_r] = in_sample;
          if (pn >= n) begin
            pn       = '0;
            full_nxt = 1'b1;
          end
          wpos_nxt  = AW'(pn);
          count_nxt = full_nxt ? n : pn;
        end
        wmaf_pkg::OP_REINIT, wmaf_pkg::OP_CLEAR: begin
          for (int k = 0; k < MAX_WINDOW; k++) hist_nxt[k] = '0;
          wpos_nxt = '0;
          full_nxt = 1'b0;
        end
        default: begin
          if (stat.custom_ok) wtab_nxt[widx] = WW'(in_weight_value);
          else res_status_nxt = wmaf_pkg::STATUS_REJECT;
        end
      endcase
    end

    if (cmd.sweep_step) begin
      if (op_r == wmaf_pkg::OP_REINIT) begin
        wtab_nxt[cnt_r[AW-1:0]] = wsweep;
        factor_nxt              = 17'(mul_f >> wmaf_pkg::ALPHA_BITS);
      end
      sum_nxt = sum_r + TW'(wsweep);
      cnt_nxt = cnt_r + CW'(1);
      if (stat.sweep_last) begin
        total_nxt = sum_nxt;
        if (op_r == wmaf_pkg::OP_CUSTOM && sum_nxt == '0) begin
          res_status_nxt = wmaf_pkg::STATUS_ZERO;
        end
      end
    end

    if (cmd.mac_step) begin
      if (pvalid_r) acc_nxt = acc_r + prod_r;
      pvalid_nxt = cnt_r < CW'(count_r);
      prod_nxt   = ACCW'($signed(hist_r[hidx]) *
                         $signed({1'b0, wtab_r[cnt_r[AW-1:0]]}));
      if (pvalid_nxt) cnt_nxt = cnt_r + CW'(1);
    end

    if (cmd.div_start) begin
      neg_nxt = acc_r[ACCW-1];
      dvd_nxt = acc_mag;
      rem_nxt = '0;
      cnt_nxt = '0;
      if (stat.total_zero) res_status_nxt = wmaf_pkg::STATUS_ZERO;
    end

    // restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      rem_nxt = ge ? TW'(rem_sh - {1'b0, total_r}) : rem_sh[TW-1:0];
      dvd_nxt = {dvd_r[ACCW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
    end

    if (cmd.div_finish) begin
      if (!neg_r) res_filtered_nxt = (dvd_r > SAT_HI) ? OUT_HI : dvd_r[SAMPLE_BITS-1:0];
      else if (dvd_r > SAT_HI + ACCW'(1)) res_filtered_nxt = OUT_LO;
      else res_filtered_nxt = SAMPLE_BITS'(~dvd_r + ACCW'(1));
    end

    if (cmd.out_load) begin
      out_filtered_nxt = res_filtered_r;
      out_status_nxt   = res_status_r;
    end
  end

  always_comb begin
    stat.custom_ok  = (weight_mode == wmaf_pkg::MODE_CUSTOM) &&
                      (32'(in_weight_index) < 32'(n));
    stat.sweep_last = cnt_r == CW'(MAX_WINDOW - 1);
    stat.mac_done   = !(cnt_r < CW'(count_r)) && !pvalid_r;
    stat.total_zero = total_r == '0;
    stat.div_done   = cnt_r == CW'(ACCW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        hist_r[k] <= '0;
        wtab_r[k] <= WEIGHT_ONE;
      end
      wpos_r   <= '0;
      full_r   <= 1'b0;
      total_r  <= TOTAL_RST;
      pvalid_r <= 1'b0;
      cnt_r    <= '0;
      count_r  <= '0;
      op_r     <= wmaf_pkg::OP_SAMPLE;
    end else begin
      hist_r   <= hist_nxt;
      wtab_r   <= wtab_nxt;
      wpos_r   <= wpos_nxt;
      full_r   <= full_nxt;
      total_r  <= total_nxt;
      pvalid_r <= pvalid_nxt;
      cnt_r    <= cnt_nxt;
      count_r  <= count_nxt;
      op_r     <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r          <= sum_nxt;
    acc_r          <= acc_nxt;
    prod_r         <= prod_nxt;
    factor_r       <= factor_nxt;
    dvd_r          <= dvd_nxt;
    rem_r          <= rem_nxt;
    neg_r          <= neg_nxt;
    res_filtered_r <= res_filtered_nxt;
    res_status_r   <= res_status_nxt;
    out_filtered_r <= out_filtered_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign out_filtered = $signed(out_filtered_r);
  assign out_status   = out_status_r;

  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wpos_r) < MAX_WINDOW)
    else $error("write position out of range");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < total_r))
    else $error("divider remainder not reduced");

endmodule
`default_nettype wire

>>> hdl/weighted_moving_average_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_moving_average_filter_top
// Windowed weighted average of signed samples with selectable weight profile.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   operation, sample, weight index/value
//   out_     output     out_valid/out_stall filtered, status
//   apb      config     psel/penable/pready window_length, weight_mode, alpha
//
// sample: a multiply-accumulate over the filled taps, then (unless the weight sum is
//   zero) a restoring divide over SAMPLE_BITS+WEIGHT_FRAC_BITS+8+log2(MAX_WINDOW)
//   dividend bits (45 at defaults) and a finish step that restores sign and saturates.
// reinitialize and an accepted custom weight write sweep all MAX_WINDOW weight entries.
// reset is synchronous; tables come up with zero history and unit weights.
// a waiting result sits in the output register; the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module weighted_moving_average_filter_top #(
  parameter int MAX_WINDOW       = wmaf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS      = wmaf_pkg::SAMPLE_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = wmaf_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [4:0]                    in_weight_index,
  input  wire logic [23:0]                   in_weight_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_filtered,
  output logic [1:0]                         out_status,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  wmaf_pkg::cmd_t  cmd;
  wmaf_pkg::stat_t stat;
  logic [5:0]      window_length;
  logic [2:0]      weight_mode;
  logic [16:0]     decay_alpha;

  wmaf_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_length (window_length),
    .weight_mode   (weight_mode),
    .decay_alpha   (decay_alpha)
  );

  wmaf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  wmaf_dp #(
    .MAX_WINDOW       (MAX_WINDOW),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_sample       (in_sample),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .window_length   (window_length),
    .weight_mode     (weight_mode),
    .decay_alpha     (decay_alpha),
    .out_filtered    (out_filtered),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire
